[hw/rtl/multi_queue_strict_priority_core_defines.svh]
// Assertion macros used by the strict priority multi-queue datapath.
`ifndef MULTI_QUEUE_STRICT_PRIORITY_CORE_DEFINES_SVH
`define MULTI_QUEUE_STRICT_PRIORITY_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MQSP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mqsp assertion failed");

// Next-cycle implication, checked outside reset.
`define MQSP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mqsp assertion failed");

`endif

[hw/rtl/mqsp_pkg.sv]
// Shared constants, status codes and control structs of the multi-queue.
package mqsp_pkg;

  // Default sizes handed to the top level parameters.
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int NUM_CLASSES_DEF = 4;
  localparam int CLASS_DEPTH_DEF = 16;

  // Field widths.
  localparam int QNUM_W     = 4;
  localparam int CLASS_W    = 2;
  localparam int ID_W       = 16;
  localparam int STATUS_W   = 3;
  localparam int ACTIVE_W   = 4;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  // Operation codes.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ENQ   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEQ   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADQ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_item;
    logic                clear;
    logic                rec_rd;
    logic                act;
    logic                set_res;
    logic [STATUS_W-1:0] res_code;
    logic                res_from_store;
    logic                load_out;
  } mqsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic q_ok;
    logic is_enq;
    logic found;
    logic full;
    logic out_free;
  } mqsp_stat_t;

endpackage

[hw/rtl/mqsp_ctrl.sv]
// Sequencer that steps each item through check, pointer access and result.
module mqsp_ctrl
  import mqsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  mqsp_stat_t st,
  output mqsp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_CHECK  = 6'b000100,
    S_ACT    = 6'b001000,
    S_ENT    = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_code = ST_ENQ;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!st.q_ok) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_BADQ;
          state_next   = S_RESULT;
        end else if (st.is_enq || st.found) begin
          cmd.rec_rd = 1'b1;
          state_next = S_ACT;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_EMPTY;
          state_next   = S_RESULT;
        end
      end
      S_ACT: begin
        cmd.act = 1'b1;
        if (st.is_enq) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = st.full ? ST_FULL : ST_ENQ;
          state_next   = S_RESULT;
        end else begin
          state_next = S_ENT;
        end
      end
      S_ENT: begin
        cmd.set_res        = 1'b1;
        cmd.res_code       = ST_DEQ;
        cmd.res_from_store = 1'b1;
        state_next         = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register; reset starts the pointer clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/mqsp_dpath.sv]
// Datapath: item latch, pointer and entry memories, class flags, output register.
`include "multi_queue_strict_priority_core_defines.svh"
module mqsp_dpath
  import mqsp_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mqsp_cmd_t             cmd,
  output mqsp_stat_t            st,
  input  logic                  in_func,
  input  logic [QNUM_W-1:0]     in_queue_number,
  input  logic [CLASS_W-1:0]    in_priority_class,
  input  logic [ID_W-1:0]       in_entry_id,
  input  logic                  cfg_valid,
  input  logic [ACTIVE_W-1:0]   cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ID_W-1:0]       out_entry_id
);

  localparam int FIFO_COUNT  = NUM_QUEUES * NUM_CLASSES;
  localparam int FIFO_W      = $clog2(FIFO_COUNT);
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int PTR_W       = $clog2(CLASS_DEPTH);
  localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
  localparam int REC_W       = 2 * PTR_W + CNT_W;
  localparam int STORE_DEPTH = FIFO_COUNT * CLASS_DEPTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Item registers.
  logic                func_reg;
  logic [QNUM_W-1:0]   q_reg;
  logic [CLASS_W-1:0]  cls_reg;
  logic [ID_W-1:0]     id_reg;

  logic [ACTIVE_W-1:0] active_q;
  logic [FIFO_W-1:0]   clear_idx;
  logic [FIFO_W-1:0]   fifo_idx;
  logic [FIFO_COUNT-1:0] nonempty;

  // Memories.
  logic [REC_W-1:0]    rec_mem [FIFO_COUNT];
  logic [REC_W-1:0]    rec_q;
  logic [ID_W-1:0]     store_mem [STORE_DEPTH];
  logic [ID_W-1:0]     store_q;

  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;

  logic                q_ok;
  logic                is_enq;
  logic [FIFO_W-1:0]   base;
  logic [CLS_W-1:0]    cls_sat;
  logic [FIFO_W-1:0]   enq_idx;
  logic [FIFO_W-1:0]   deq_idx;
  logic                found;
  logic [CLS_W-1:0]    found_cls;

  logic [PTR_W-1:0]    rec_head;
  logic [PTR_W-1:0]    rec_tail;
  logic [CNT_W-1:0]    rec_cnt;
  logic                full;

  logic                rec_we;
  logic [FIFO_W-1:0]   rec_wa;
  logic [REC_W-1:0]    rec_wd;
  logic                store_we;
  logic                store_re;
  logic [STORE_AW-1:0] store_addr;
  logic                flag_we;
  logic                flag_wd;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Queue validity against the configured and built queue counts.
  assign q_ok   = (q_reg != '0) && (int'(q_reg) <= NUM_QUEUES) && (q_reg <= active_q);
  assign is_enq = (func_reg == FUNC_ENQ);

  // FIFO index of the addressed class; an out-of-range class maps to the highest numbered class.
  assign base    = FIFO_W'(q_reg - QNUM_W'(1)) * FIFO_W'(NUM_CLASSES);
  assign cls_sat = (int'(cls_reg) >= NUM_CLASSES) ? CLS_W'(NUM_CLASSES - 1) : CLS_W'(cls_reg);
  assign enq_idx = base + FIFO_W'(cls_sat);
  assign deq_idx = base + FIFO_W'(found_cls);

  // Highest priority non-empty class of the queue.
  always_comb begin
    found     = 1'b0;
    found_cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (nonempty[base + FIFO_W'(c)]) begin
        found     = 1'b1;
        found_cls = CLS_W'(c);
      end
    end
  end

  // Pointer record fields.
  assign rec_cnt  = rec_q[CNT_W-1:0];
  assign rec_tail = rec_q[CNT_W +: PTR_W];
  assign rec_head = rec_q[CNT_W + PTR_W +: PTR_W];
  assign full     = (rec_cnt == CNT_W'(CLASS_DEPTH));

  // Record and flag updates for the act step, or zeroing during the clear pass.
  always_comb begin
    rec_we = cmd.clear || (cmd.act && !(is_enq && full));
    rec_wa = cmd.clear ? clear_idx : fifo_idx;
    if (cmd.clear) begin
      rec_wd = '0;
    end else if (is_enq) begin
      rec_wd = {rec_head, ptr_inc(rec_tail), rec_cnt + CNT_W'(1)};
    end else begin
      rec_wd = {ptr_inc(rec_head), rec_tail, rec_cnt - CNT_W'(1)};
    end
    flag_we    = cmd.act && !(is_enq && full);
    flag_wd    = is_enq ? 1'b1 : (rec_cnt != CNT_W'(1));
    store_we   = cmd.act && is_enq && !full;
    store_re   = cmd.act && !is_enq;
    store_addr = STORE_AW'(fifo_idx) * STORE_AW'(CLASS_DEPTH)
               + STORE_AW'(is_enq ? rec_tail : rec_head);
  end

  // Status to the controller.
  always_comb begin
    st.clear_last = (clear_idx == FIFO_W'(FIFO_COUNT - 1));
    st.q_ok       = q_ok;
    st.is_enq     = is_enq;
    st.found      = found;
    st.full       = full;
    st.out_free   = !out_valid || out_ready;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_q  <= ACTIVE_RESET;
      clear_idx <= '0;
      nonempty  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) active_q <= cfg_data;
      if (cmd.clear) clear_idx <= clear_idx + FIFO_W'(1);
      if (flag_we) nonempty[fifo_idx] <= flag_wd;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_reg <= in_func;
      q_reg    <= in_queue_number;
      cls_reg  <= in_priority_class;
      id_reg   <= in_entry_id;
    end
    if (cmd.rec_rd) fifo_idx <= is_enq ? enq_idx : deq_idx;
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_id     <= cmd.res_from_store ? store_q : '0;
    end
    if (cmd.load_out) begin
      out_status   <= res_status;
      out_entry_id <= res_id;
    end
  end

  // Pointer record memory.
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (cmd.rec_rd) rec_q <= rec_mem[is_enq ? enq_idx : deq_idx];
  end

  // Entry memory, at most one access per item.
  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_addr] <= id_reg;
    if (store_re) store_q <= store_mem[store_addr];
  end

  // Class flags track the fill counts, counts stay bounded, ids only on dequeue.
  `MQSP_ASSERT_IMP(a_flag_matches_count, clk, rst, cmd.act, nonempty[fifo_idx] == (rec_cnt != '0))
  `MQSP_ASSERT_IMP(a_count_bounded, clk, rst, cmd.act, rec_cnt <= CNT_W'(CLASS_DEPTH))
  `MQSP_ASSERT_NXT(a_enq_sets_flag, clk, rst, cmd.act && is_enq && !full, nonempty[fifo_idx])
  `MQSP_ASSERT_IMP(a_id_zero_unless_deq, clk, rst, out_valid && out_status != ST_DEQ, out_entry_id == '0)

endmodule

[hw/rtl/multi_queue_strict_priority_core.sv]
// Top level of the strict priority multi-queue: controller plus datapath.
//
// Items enter on the s_axis channel: tuser carries the operation (enqueue or
// dequeue), tdata carries queue number, class and entry id. Each item gives
// exactly one result item on m_axis: tuser is the status, tdata the dequeued id.
// The user must write active_queues over cfg only while idle; it is not enforced.
//
// One item is handled at a time by a sequencer around two registered memory
// reads (pointer record, then entry). A bad or empty queue goes from the check
// state straight to the result; enqueue and class full pass the act state, and
// a dequeue passes act and then the entry read state. The next item is accepted
// only in the idle state after the result is loaded into the output register,
// so the block takes no new item before the last one is through.
//
// After reset a clearing pass zeroes the pointer memory, one FIFO record a
// cycle; s_axis_tready stays low meanwhile. If the receiver stalls, the
// result waits in the output register and the next item is processed up to
// its result, then holds until the slot frees.
module multi_queue_strict_priority_core
  import mqsp_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: queue_number [3:0], priority_class [5:4], entry_id [21:6], zero [23:22]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func [0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: out_entry_id [15:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: status [2:0]
  output logic [STATUS_W-1:0]    m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ACTIVE_W-1:0]    cfg_data
);

  mqsp_cmd_t  cmd;
  mqsp_stat_t st;

  // The register write is always taken.
  assign cfg_ready = 1'b1;

  mqsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mqsp_dpath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .NUM_CLASSES (NUM_CLASSES),
    .CLASS_DEPTH (CLASS_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .in_func           (s_axis_tuser),
    .in_queue_number   (s_axis_tdata[3:0]),
    .in_priority_class (s_axis_tdata[5:4]),
    .in_entry_id       (s_axis_tdata[21:6]),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_status        (m_axis_tuser),
    .out_entry_id      (m_axis_tdata)
  );

endmodule
